FILE: sv/qsed_pkg.sv
package qsed_pkg;

  // Decoder modes
  localparam logic [2:0] M_BETWEEN   = 3'd0;
  localparam logic [2:0] M_STRING    = 3'd1;
  localparam logic [2:0] M_ESCAPE    = 3'd2;
  localparam logic [2:0] M_OCTAL     = 3'd3;
  localparam logic [2:0] M_HEX_FIRST = 3'd4;
  localparam logic [2:0] M_HEX       = 3'd5;
  localparam logic [2:0] M_ERROR     = 3'd6;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam int unsigned MaxResults = 3;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_V   = 8'h76;
  localparam logic [7:0] CH_LO_X   = 8'h78;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] escape_value;
    logic [1:0] digit_count;
    logic       segment_seen;
  } dec_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } nibble_t;

  function automatic nibble_t hex_nibble(input logic [7:0] b);
    nibble_t r;
    r = '0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      r.valid = 1'b1;
      r.value = b[3:0];
    end else if ((b >= CH_LO_A && b <= CH_LO_F) || (b >= CH_UP_A && b <= CH_UP_F)) begin
      r.valid = 1'b1;
      r.value = b[3:0] + 4'd9;
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

endpackage

FILE: sv/qsed_text_if.sv
interface qsed_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

FILE: sv/qsed_result_if.sv
interface qsed_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] decoded_byte;
  logic       run_last;

  modport source (output valid, output result_kind, output decoded_byte, output run_last,
                  input ready);
  modport sink (input valid, input result_kind, input decoded_byte, input run_last,
                output ready);
endinterface

FILE: sv/qsed_step.sv
module qsed_step (
  input  qsed_pkg::dec_state_t state_i,
  input  logic [7:0]           byte_i,
  input  logic                 end_i,
  output qsed_pkg::dec_state_t state_o,
  output qsed_pkg::result_t    res_o [qsed_pkg::MaxResults],
  output logic [1:0]           count_o
);
  import qsed_pkg::*;

  nibble_t    nib;
  logic [1:0] dc_inc;
  logic [7:0] oct_val;

  assign nib     = hex_nibble(byte_i);
  assign dc_inc  = state_i.digit_count + 2'd1;
  assign oct_val = {state_i.escape_value[4:0], byte_i[2:0]};

  always_comb begin
    state_o = state_i;
    count_o = 2'd0;
    for (int k = 0; k < MaxResults; k++) begin
      res_o[k] = '0;
    end

    if (state_i.mode != M_ERROR && byte_i == CH_NUL) begin
      state_o.mode = M_ERROR;
    end else begin
      unique case (state_i.mode)
        M_BETWEEN: begin
          if (byte_i == CH_QUOTE) begin
            state_o.mode         = M_STRING;
            state_o.segment_seen = 1'b1;
          end else if (!is_space(byte_i)) begin
            state_o.mode = M_ERROR;
          end
        end
        M_STRING: begin
          if (byte_i == CH_QUOTE) begin
            state_o.mode = M_BETWEEN;
          end else if (byte_i == CH_BSLASH) begin
            state_o.mode = M_ESCAPE;
          end else begin
            res_o[count_o] = '{kind: KIND_BYTE, data: byte_i};
            count_o        = count_o + 2'd1;
          end
        end
        M_ESCAPE: begin
          state_o.mode = M_STRING;
          if (byte_i >= CH_ZERO && byte_i <= CH_SEVEN) begin
            state_o.escape_value = {5'd0, byte_i[2:0]};
            state_o.digit_count  = 2'd1;
            state_o.mode         = M_OCTAL;
          end else if (byte_i == CH_LO_X) begin
            state_o.escape_value = 8'd0;
            state_o.mode         = M_HEX_FIRST;
          end else begin
            res_o[count_o].kind = KIND_BYTE;
            unique case (byte_i)
              CH_LO_A: res_o[count_o].data = 8'd7;
              CH_LO_B: res_o[count_o].data = 8'd8;
              CH_LO_F: res_o[count_o].data = 8'd12;
              CH_LO_N: res_o[count_o].data = 8'd10;
              CH_LO_R: res_o[count_o].data = 8'd13;
              CH_LO_T: res_o[count_o].data = 8'd9;
              CH_LO_V: res_o[count_o].data = 8'd11;
              default: res_o[count_o].data = byte_i;
            endcase
            count_o = count_o + 2'd1;
          end
        end
        M_OCTAL: begin
          if (byte_i >= CH_ZERO && byte_i <= CH_SEVEN) begin
            state_o.escape_value = oct_val;
            state_o.digit_count  = dc_inc;
            if (dc_inc == 2'd3) begin
              res_o[count_o]       = '{kind: KIND_BYTE, data: oct_val};
              count_o              = count_o + 2'd1;
              state_o.escape_value = 8'd0;
              state_o.digit_count  = 2'd0;
              state_o.mode         = M_STRING;
            end
          end else begin
            // flush the pending value, then treat the byte as ordinary
            res_o[count_o]       = '{kind: KIND_BYTE, data: state_i.escape_value};
            count_o              = count_o + 2'd1;
            state_o.escape_value = 8'd0;
            state_o.digit_count  = 2'd0;
            state_o.mode         = M_STRING;
            if (byte_i == CH_QUOTE) begin
              state_o.mode = M_BETWEEN;
            end else if (byte_i == CH_BSLASH) begin
              state_o.mode = M_ESCAPE;
            end else begin
              res_o[count_o] = '{kind: KIND_BYTE, data: byte_i};
              count_o        = count_o + 2'd1;
            end
          end
        end
        M_HEX_FIRST: begin
          if (!nib.valid) begin
            state_o.mode = M_ERROR;
          end else begin
            state_o.escape_value = {4'd0, nib.value};
            state_o.mode         = M_HEX;
          end
        end
        M_HEX: begin
          if (nib.valid) begin
            state_o.escape_value = {state_i.escape_value[3:0], nib.value};
          end else begin
            res_o[count_o]       = '{kind: KIND_BYTE, data: state_i.escape_value};
            count_o              = count_o + 2'd1;
            state_o.escape_value = 8'd0;
            state_o.mode         = M_STRING;
            if (byte_i == CH_QUOTE) begin
              state_o.mode = M_BETWEEN;
            end else if (byte_i == CH_BSLASH) begin
              state_o.mode = M_ESCAPE;
            end else begin
              res_o[count_o] = '{kind: KIND_BYTE, data: byte_i};
              count_o        = count_o + 2'd1;
            end
          end
        end
        default: begin
          state_o.mode = M_ERROR;
        end
      endcase
    end

    if (end_i) begin
      res_o[count_o].kind = (state_o.mode == M_BETWEEN && state_o.segment_seen)
                            ? KIND_OK : KIND_ERR;
      res_o[count_o].data = 8'd0;
      count_o             = count_o + 2'd1;
      state_o             = '{mode: M_BETWEEN, escape_value: 8'd0, digit_count: 2'd0,
                              segment_seen: 1'b0};
    end
  end

endmodule

FILE: sv/quoted_string_escape_decoder_core.sv
// Quoted string escape decoder.
// Channels: text_i takes one byte of a value text per transfer, with text_end
// marking the final byte; result_o gives decoded bytes and, after the final
// byte, one ok or error status. run_last flags the last result of each byte.
// Pipeline: an input register holds the accepted byte; the decode step reads
// it with the decoder state and loads the results of that byte (none to
// three) into a run register, which drains one result per transfer.
// Path: a byte's results pass through the input register and then the run
// register before result_o offers them. Throughput: one byte per cycle while
// result_o is ready and each byte yields at most one result; a byte yielding
// k results holds the run register for k output transfers.
// Bytes that yield nothing (whitespace, quotes, escape prefixes) pass through
// at one per cycle even while a run waits.
// Stall: when result_o is not ready the run register holds, the input
// register fills and then text_i.ready drops; nothing is lost.
// Reset: rst_ni clears both registers' valid flags and puts the decoder
// between segments with no segment seen.
module quoted_string_escape_decoder_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  qsed_text_if.sink            text_i,
  qsed_result_if.source        result_o
);
  import qsed_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  // decoder state
  dec_state_t state_q, state_d;

  // run register: results of one byte, drained slot by slot
  result_t    run_q [MaxResults];
  result_t    step_res [MaxResults];
  logic [1:0] step_cnt;
  logic       run_valid_q;
  logic [1:0] run_cnt_q;
  logic [1:0] run_idx_q;

  logic run_at_last;
  logic run_free;
  logic consume;

  qsed_step u_step (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .end_i   (in_end_q),
    .state_o (state_d),
    .res_o   (step_res),
    .count_o (step_cnt)
  );

  assign run_at_last = (run_idx_q == run_cnt_q - 2'd1);
  // run register can take a new run this cycle
  assign run_free    = !run_valid_q || (result_o.ready && run_at_last);
  // advance the input register when its results have somewhere to go
  assign consume     = in_valid_q && ((step_cnt == 2'd0) || run_free);

  assign text_i.ready = !in_valid_q || consume;

  assign result_o.valid        = run_valid_q;
  assign result_o.result_kind  = run_q[run_idx_q].kind;
  assign result_o.decoded_byte = run_q[run_idx_q].data;
  assign result_o.run_last     = run_at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (text_i.ready) begin
      in_valid_q <= text_i.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (text_i.ready && text_i.valid) begin
      in_byte_q <= text_i.text_byte;
      in_end_q  <= text_i.text_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: M_BETWEEN, escape_value: 8'd0, digit_count: 2'd0,
                   segment_seen: 1'b0};
    end else if (consume) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      run_cnt_q   <= 2'd0;
      run_idx_q   <= 2'd0;
    end else if (consume && step_cnt != 2'd0) begin
      // load a fresh run; run_free guaranteed the old one is gone
      run_valid_q <= 1'b1;
      run_cnt_q   <= step_cnt;
      run_idx_q   <= 2'd0;
    end else if (run_valid_q && result_o.ready) begin
      if (run_at_last) begin
        run_valid_q <= 1'b0;
      end else begin
        run_idx_q <= run_idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && step_cnt != 2'd0) begin
      for (int k = 0; k < MaxResults; k++) begin
        run_q[k] <= step_res[k];
      end
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import qsed_pkg::*;

  // Control codes produced by the single-letter escapes. Tab and carriage
  // return come from the package.
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;

  localparam int unsigned RandomBytes = 220;
  localparam int unsigned DrainCycles = 20;

  // One expected or observed result transfer
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } decoded_rec_t;

  logic clk_i;
  logic rst_ni;

  qsed_text_if   text_if ();
  qsed_result_if res_if ();

  quoted_string_escape_decoder_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_if.sink),
    .result_o(res_if.source)
  );

  // Decoder state as the predictor sees it
  logic [2:0] dec_mode;
  logic [7:0] esc_acc;
  logic [1:0] oct_digits;
  logic       seg_seen;

  // Results of the byte being predicted, then the queue of decoded results
  // still owed by the block, oldest first
  decoded_rec_t byte_results[$];
  decoded_rec_t owed_results[$];

  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned stall_left;
  bit          steady;   // suppress idling on both channels while set

  // Clock and hard timeout
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic void clear_decoder();
    dec_mode   = M_BETWEEN;
    esc_acc    = '0;
    oct_digits = '0;
    seg_seen   = 1'b0;
  endfunction

  function automatic bit blank_char(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // Hex digit value, or -1 for anything that is not a hex digit
  function automatic int hex_value(input logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
    if (b >= CH_LO_A && b <= CH_LO_F) return int'(b - CH_LO_A) + 10;
    if (b >= CH_UP_A && b <= CH_UP_F) return int'(b - CH_UP_A) + 10;
    return -1;
  endfunction

  // A byte can cause three results at most; drop anything past that
  function automatic void add_result(input logic [1:0] kind, input logic [7:0] data);
    if (byte_results.size() < MaxResults) byte_results.push_back('{kind, data, 1'b0});
  endfunction

  function automatic void segment_char(input logic [7:0] b);
    if (b == CH_QUOTE) dec_mode = M_BETWEEN;
    else if (b == CH_BSLASH) dec_mode = M_ESCAPE;
    else add_result(KIND_BYTE, b);
  endfunction

  // Emit the collected numeric escape and fall back into the segment
  function automatic void flush_numeric();
    add_result(KIND_BYTE, esc_acc);
    esc_acc    = '0;
    oct_digits = '0;
    dec_mode   = M_STRING;
  endfunction

  // Advance the predictor by one accepted byte and queue what it owes
  function automatic void predict_byte(input logic [7:0] b, input logic fin);
    int d;
    byte_results = {};
    d = hex_value(b);
    if (dec_mode != M_ERROR && b == CH_NUL) begin
      // a zero byte is fatal anywhere and flushes nothing
      dec_mode = M_ERROR;
    end else begin
      case (dec_mode)
        M_BETWEEN: begin
          if (b == CH_QUOTE) begin
            dec_mode = M_STRING;
            seg_seen = 1'b1;
          end else if (!blank_char(b)) begin
            dec_mode = M_ERROR;
          end
        end
        M_STRING: segment_char(b);
        M_ESCAPE: begin
          dec_mode = M_STRING;
          case (b)
            CH_LO_A: add_result(KIND_BYTE, CH_BEL);
            CH_LO_B: add_result(KIND_BYTE, CH_BS);
            CH_LO_F: add_result(KIND_BYTE, CH_FF);
            CH_LO_N: add_result(KIND_BYTE, CH_LF);
            CH_LO_R: add_result(KIND_BYTE, CH_CR);
            CH_LO_T: add_result(KIND_BYTE, CH_TAB);
            CH_LO_V: add_result(KIND_BYTE, CH_VT);
            CH_LO_X: begin
              esc_acc  = '0;
              dec_mode = M_HEX_FIRST;
            end
            default: begin
              if (b >= CH_ZERO && b <= CH_SEVEN) begin
                esc_acc    = b - CH_ZERO;
                oct_digits = 2'd1;
                dec_mode   = M_OCTAL;
              end else begin
                add_result(KIND_BYTE, b);   // escaped byte stands for itself
              end
            end
          endcase
        end
        M_OCTAL: begin
          if (b >= CH_ZERO && b <= CH_SEVEN) begin
            // shift in three bits, keep the low byte
            esc_acc    = {esc_acc[4:0], b[2:0]};
            oct_digits = oct_digits + 2'd1;
            if (oct_digits == 2'd3) flush_numeric();
          end else begin
            flush_numeric();
            segment_char(b);
          end
        end
        M_HEX_FIRST: begin
          if (d < 0) begin
            dec_mode = M_ERROR;
          end else begin
            esc_acc  = 8'(d);
            dec_mode = M_HEX;
          end
        end
        M_HEX: begin
          if (d >= 0) begin
            esc_acc = {esc_acc[3:0], 4'(d)};
          end else begin
            flush_numeric();
            segment_char(b);
          end
        end
        default: dec_mode = M_ERROR;   // error mode and the spare code
      endcase
    end

    if (fin) begin
      add_result((dec_mode == M_BETWEEN && seg_seen) ? KIND_OK : KIND_ERR, '0);
      clear_decoder();
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    foreach (byte_results[i]) owed_results.push_back(byte_results[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Channel activity
  // --------------------------------------------------------------------------

  // Mostly short idle stretches with the odd long one
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 8);
    return $urandom_range(12, 30);
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Send one byte: optional idle gap, then hold it until the transfer.
  // Returns at the falling edge after the transfer with valid still high.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = (!steady && $urandom_range(0, 99) < 35) ? idle_length() : 0;
    if (gap > 0) begin
      text_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    text_if.valid     = 1'b1;
    text_if.text_byte = b;
    text_if.text_end  = fin;
    do @(posedge clk_i); while (!text_if.ready);
    predict_byte(b, fin);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  task automatic stop_sending();
    text_if.valid = 1'b0;
  endtask

  // Hold the sender until the block has delivered everything it owes
  task automatic wait_drained();
    stop_sending();
    while (owed_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Receiver: random back-pressure, decided at the falling edge
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      res_if.ready = 1'b0;
      stall_left--;
    end else begin
      res_if.ready = 1'b1;
      if (!steady && $urandom_range(0, 99) < 30) stall_left = idle_length();
    end
  end

  // Compare every result transfer with the oldest owed result
  always @(posedge clk_i) begin : check_results
    decoded_rec_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                  res_if.result_kind, res_if.decoded_byte));
      end else begin
        want = owed_results.pop_front();
        if (res_if.result_kind !== want.kind)
          report_mismatch($sformatf("result_kind %0d, want %0d",
                                    res_if.result_kind, want.kind));
        if (res_if.decoded_byte !== want.data)
          report_mismatch($sformatf("decoded_byte %02h, want %02h",
                                    res_if.decoded_byte, want.data));
        if (res_if.run_last !== want.last)
          report_mismatch($sformatf("run_last %0b, want %0b", res_if.run_last, want.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Random text construction
  // --------------------------------------------------------------------------

  function automatic logic [7:0] blank_pick();
    return ($urandom_range(0, 2) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  // Any byte that is plain inside a segment
  function automatic logic [7:0] plain_pick();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] hex_pick();
    case ($urandom_range(0, 2))
      0:       return CH_ZERO + 8'($urandom_range(0, 9));
      1:       return CH_LO_A + 8'($urandom_range(0, 5));
      default: return CH_UP_A + 8'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] letter_pick();
    logic [7:0] letters[7];
    letters = '{CH_LO_A, CH_LO_B, CH_LO_F, CH_LO_N, CH_LO_R, CH_LO_T, CH_LO_V};
    return letters[$urandom_range(0, 6)];
  endfunction

  // Build and send one text: mostly well-formed segments with random content,
  // sometimes broken on purpose, sometimes plain noise
  task automatic send_random_text();
    logic [7:0]  t[$];
    int unsigned n;
    int unsigned pos;
    t = {};
    if ($urandom_range(0, 99) < 10) begin
      n = $urandom_range(1, 6);
      repeat (n) t.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) t.push_back(blank_pick());
      repeat ($urandom_range(1, 3)) begin
        t.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: t.push_back(plain_pick());
            4: begin
              t.push_back(CH_BSLASH);
              t.push_back(letter_pick());
            end
            5, 6: begin
              t.push_back(CH_BSLASH);
              repeat ($urandom_range(1, 3)) t.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
            end
            7: begin
              t.push_back(CH_BSLASH);
              t.push_back(CH_LO_X);
              n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
              repeat (n) t.push_back(hex_pick());
            end
            default: begin
              t.push_back(CH_BSLASH);
              case ($urandom_range(0, 3))
                0:       t.push_back(CH_QUOTE);
                1:       t.push_back(CH_BSLASH);
                default: t.push_back(8'($urandom_range(1, 255)));
              endcase
            end
          endcase
        end
        t.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 2)) t.push_back(blank_pick());
      end

      if ($urandom_range(0, 99) < 20) begin
        pos = $urandom_range(0, t.size() - 1);
        case ($urandom_range(0, 5))
          0: t.insert(pos, CH_NUL);
          1: begin
            // drop the closing quote so the text ends open
            while (t[t.size() - 1] != CH_QUOTE) void'(t.pop_back());
            void'(t.pop_back());
          end
          2: t[pos] = 8'($urandom_range(0, 255));
          3: t.push_back(plain_pick());
          4: begin
            t.push_back(CH_QUOTE);
            t.push_back(CH_BSLASH);
          end
          default: begin
            t.push_back(CH_QUOTE);
            t.push_back(CH_BSLASH);
            t.push_back(CH_LO_X);
          end
        endcase
      end
    end
    send_seq(t);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Plain segments, whitespace around and between them, extreme byte values
  task automatic test_segments();
    send_text(" \"ab\"\t\"~\" ");
    send_seq('{CH_QUOTE, 8'hFF, 8'h01, CH_QUOTE});
  endtask

  // Every single-letter escape plus escaped backslash, quote and other byte
  task automatic test_letter_escapes();
    send_text("\"\\a\\b\\f\\n\\r\\t\\v\\\\\\\"\\q\"");
  endtask

  // Octal: short, full, overflowing, ended by a quote; hex: long and wrapping
  task automatic test_numeric_escapes();
    send_text("\"\\3770\\777\\12\"");
    send_text("\"\\x41g\\xfFfF1\\x7\"");
  endtask

  // Each way a text can end in error, and absorption after an error
  task automatic test_error_endings();
    send_text("\"a\" z\"b\"");       // text outside quotes, later bytes absorbed
    send_text("\"open");             // open quote at the end
    send_text("\"\\");               // backslash at the end
    send_text("\"\\xq\"");           // hex escape with no digit
    send_text(" \t");                // no segment at all
    send_text("\"\\12");             // numeric escape still open at the end
    send_seq('{CH_QUOTE, CH_LO_A, CH_NUL, CH_LO_B, CH_QUOTE});
    send_seq('{CH_QUOTE, CH_BSLASH, CH_SEVEN, CH_NUL, CH_QUOTE});
    send_byte(CH_NUL, 1'b1);
  endtask

  task automatic test_random_texts();
    int unsigned target;
    int unsigned texts;
    target = bytes_sent + RandomBytes;
    texts  = 0;
    while (bytes_sent < target) begin
      // switch idling off for some stretches
      if (texts % 8 == 0) steady = ($urandom_range(0, 3) == 0);
      if (texts == 4) wait_drained();
      send_random_text();
      texts++;
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_ni            = 1'b0;
    text_if.valid     = 1'b0;
    text_if.text_byte = '0;
    text_if.text_end  = 1'b0;
    res_if.ready      = 1'b0;
    error_count       = 0;
    bytes_sent        = 0;
    stall_left        = 0;
    steady            = 1'b0;
    clear_decoder();

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_segments();
    test_letter_escapes();
    test_numeric_escapes();
    test_error_endings();
    test_random_texts();

    stop_sending();
    while (owed_results.size() != 0) @(posedge clk_i);
    // let any stray result surface before the verdict
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
